[hw/rtl/bpcg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpcg_pkg: button panel command generator shared definitions
// Frame identifiers, value limits, state and result types, and the per-button
// action function.
// ----------------------------------------------------------------------------
package bpcg_pkg;

    // tool codes (inverted selector switches)
    localparam logic [2:0] TOOL_DRIVE = 3'd1;
    localparam logic [2:0] TOOL_DOORS = 3'd2;
    localparam logic [2:0] TOOL_STEER = 3'd3;
    localparam logic [2:0] TOOL_FRONT = 3'd4;
    localparam logic [2:0] TOOL_REAR  = 3'd5;
    localparam logic [2:0] TOOL_SPEED = 3'd6;

    // frame identifiers
    localparam logic [10:0] ID_FORWARD = 11'h050;
    localparam logic [10:0] ID_REVERSE = 11'h060;
    localparam logic [10:0] ID_DOORS   = 11'h200;
    localparam logic [10:0] ID_SPEED   = 11'h100;
    localparam logic [10:0] ID_STEER   = 11'h101;
    localparam logic [10:0] ID_FRONT   = 11'h400;
    localparam logic [10:0] ID_REAR    = 11'h401;

    localparam logic [7:0] STEER_MAX  = 8'd180;
    localparam logic [7:0] STEER_STEP = 8'd15;
    localparam logic [7:0] DIST_MAX   = 8'd200;
    localparam logic [7:0] DIST_MIN   = 8'd10;
    localparam logic [7:0] DIST_STEP  = 8'd10;
    localparam logic [7:0] SPEED_MAX  = 8'd120;
    localparam logic [7:0] SPEED_STEP = 8'd5;
    localparam logic [2:0] DOOR_LAST  = 3'd4;

    // reset values
    localparam logic [7:0] SPEED_RST = 8'd0;
    localparam logic [7:0] STEER_RST = 8'd90;
    localparam logic [7:0] DIST_RST  = 8'd200;
    localparam logic [2:0] DOOR_RST  = 3'd0;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef logic [RES_PTR_W-1:0] res_ptr_t;
    typedef logic [RES_CNT_W-1:0] res_cnt_t;

    typedef struct packed {
        logic [7:0] speed;
        logic [7:0] steer;
        logic [7:0] front;
        logic [7:0] rear;
        logic [2:0] door;
    } state_t;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  payload;
        logic        last;
    } result_t;

    // results of one tick: how many, and the two slots in order
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } cmd_pair_t;

    typedef struct packed {
        logic    hit;
        state_t  st;
        result_t res;
    } act_t;

    function automatic logic [7:0] door_pattern(logic [2:0] idx);
        logic [7:0] p;
        case (idx)
            3'd0:    p = 8'h00;
            3'd1:    p = 8'h01;
            3'd2:    p = 8'h03;
            3'd3:    p = 8'h0F;
            3'd4:    p = 8'h3F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic act_t apply_action(state_t s, logic [2:0] tool, logic up);
        act_t a;
        a.hit          = 1'b1;
        a.st           = s;
        a.res.last     = 1'b1;
        a.res.frame_id = ID_FORWARD;
        a.res.payload  = 8'h00;
        case (tool)
            TOOL_DRIVE:
            begin
                a.res.frame_id = up ? ID_FORWARD : ID_REVERSE;
            end
            TOOL_DOORS:
            begin
                if (up)
                    a.st.door = (s.door >= DOOR_LAST) ? 3'd0 : s.door + 3'd1;
                else
                    a.st.door = (s.door == 3'd0 || s.door > DOOR_LAST) ? DOOR_LAST
                                                                       : s.door - 3'd1;
                a.res.frame_id = ID_DOORS;
                a.res.payload  = door_pattern(a.st.door);
            end
            TOOL_STEER:
            begin
                if (up && s.steer < STEER_MAX)
                    a.st.steer = s.steer + STEER_STEP;
                else if (!up && s.steer != 8'd0)
                    a.st.steer = s.steer - STEER_STEP;
                a.res.frame_id = ID_STEER;
                a.res.payload  = a.st.steer;
            end
            TOOL_FRONT:
            begin
                if (up && s.front < DIST_MAX)
                    a.st.front = s.front + DIST_STEP;
                else if (!up && s.front > DIST_MIN)
                    a.st.front = s.front - DIST_STEP;
                a.res.frame_id = ID_FRONT;
                a.res.payload  = a.st.front;
            end
            TOOL_REAR:
            begin
                if (up && s.rear < DIST_MAX)
                    a.st.rear = s.rear + DIST_STEP;
                else if (!up && s.rear > DIST_MIN)
                    a.st.rear = s.rear - DIST_STEP;
                a.res.frame_id = ID_REAR;
                a.res.payload  = a.st.rear;
            end
            TOOL_SPEED:
            begin
                if (up && s.speed < SPEED_MAX)
                    a.st.speed = s.speed + SPEED_STEP;
                else if (!up && s.speed != 8'd0)
                    a.st.speed = s.speed - SPEED_STEP;
                a.res.frame_id = ID_SPEED;
                a.res.payload  = a.st.speed;
            end
            default:
            begin
                a.hit = 1'b0;
            end
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/bpcg_action.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpcg_action: per-tick command logic
// Applies the plus action, then the minus action on the state plus left, and
// packs up to two result words in order.
// ----------------------------------------------------------------------------
module bpcg_action (
    input  wire bpcg_pkg::state_t    cur,
    input  wire logic [2:0]          tool,
    input  wire logic                plus_fall,
    input  wire logic                minus_fall,
    output bpcg_pkg::state_t         nxt,
    output bpcg_pkg::cmd_pair_t      cmds
);

    bpcg_pkg::act_t plus_act;
    bpcg_pkg::act_t minus_act;
    bpcg_pkg::state_t mid;
    logic plus_hit;
    logic minus_hit;

    always_comb
    begin
        plus_act  = bpcg_pkg::apply_action(cur, tool, 1'b1);
        plus_hit  = plus_fall && plus_act.hit;
        mid       = plus_hit ? plus_act.st : cur;
        minus_act = bpcg_pkg::apply_action(mid, tool, 1'b0);
        minus_hit = minus_fall && minus_act.hit;
        nxt       = minus_hit ? minus_act.st : mid;

        cmds.count = {1'b0, plus_hit} + {1'b0, minus_hit};
        cmds.r0    = plus_hit ? plus_act.res : minus_act.res;
        // first word is last unless minus follows it
        cmds.r0.last = !(plus_hit && minus_hit);
        cmds.r1      = minus_act.res;
    end

endmodule
`default_nettype wire

[hw/rtl/button_panel_can_command_generator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// button_panel_can_command_generator_top: button panel command generator
// Turns polled button and selector samples into command frame words.
// ----------------------------------------------------------------------------
// One input word is one polling tick. It is registered, then in one pass the
// button edges are applied to the selected tool and up to two command words
// enter a four-entry result queue, from which the first word is then shown.
// The result port drains one word per cycle while out_stall is low; a tick
// yields two frames only when both buttons fall together. The input stage
// holds a tick while the queue has fewer than two free entries.
module button_panel_can_command_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        plus_level,
    input  wire logic        minus_level,
    input  wire logic [2:0]  switch_levels,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [10:0]      frame_id,
    output logic [7:0]       payload,
    output logic             last
);

    logic       in_valid_reg;
    logic       plus_reg;
    logic       minus_reg;
    logic [2:0] sw_reg;
    logic       plus_prev_reg;
    logic       minus_prev_reg;

    bpcg_pkg::state_t    state_reg;
    bpcg_pkg::state_t    state_next;
    bpcg_pkg::cmd_pair_t cmds;

    bpcg_pkg::result_t  res_mem [bpcg_pkg::RES_DEPTH];
    bpcg_pkg::res_ptr_t wr_ptr_reg;
    bpcg_pkg::res_ptr_t rd_ptr_reg;
    bpcg_pkg::res_cnt_t count_reg;
    bpcg_pkg::res_cnt_t count_next;

    logic move;
    logic load;
    logic pop;
    logic [1:0] push_n;

    assign move     = in_valid_reg &&
                      (count_reg <= bpcg_pkg::res_cnt_t'(bpcg_pkg::RES_DEPTH - 2));
    assign in_stall = in_valid_reg && !move;
    assign load     = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;
    assign push_n   = move ? cmds.count : 2'd0;

    bpcg_action u_action (
        .cur        (state_reg),
        .tool       (~sw_reg),
        .plus_fall  (plus_prev_reg && !plus_reg),
        .minus_fall (minus_prev_reg && !minus_reg),
        .nxt        (state_next),
        .cmds       (cmds)
    );

    assign count_next = bpcg_pkg::res_cnt_t'(count_reg + bpcg_pkg::res_cnt_t'(push_n)
                                             - bpcg_pkg::res_cnt_t'(pop));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            plus_prev_reg   <= 1'b1;
            minus_prev_reg  <= 1'b1;
            state_reg.speed <= bpcg_pkg::SPEED_RST;
            state_reg.steer <= bpcg_pkg::STEER_RST;
            state_reg.front <= bpcg_pkg::DIST_RST;
            state_reg.rear  <= bpcg_pkg::DIST_RST;
            state_reg.door  <= bpcg_pkg::DOOR_RST;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (load)
                in_valid_reg <= 1'b1;
            else if (move)
                in_valid_reg <= 1'b0;
            if (move)
            begin
                plus_prev_reg  <= plus_reg;
                minus_prev_reg <= minus_reg;
                state_reg      <= state_next;
            end
            wr_ptr_reg <= bpcg_pkg::res_ptr_t'(wr_ptr_reg + bpcg_pkg::res_ptr_t'(push_n));
            if (pop)
                rd_ptr_reg <= bpcg_pkg::res_ptr_t'(rd_ptr_reg + 1'b1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plus_reg  <= plus_level;
            minus_reg <= minus_level;
            sw_reg    <= switch_levels;
        end
        if (push_n != 2'd0)
            res_mem[wr_ptr_reg] <= cmds.r0;
        if (push_n == 2'd2)
            res_mem[bpcg_pkg::res_ptr_t'(wr_ptr_reg + 1'b1)] <= cmds.r1;
    end

    assign out_valid = (count_reg != '0);
    assign frame_id  = res_mem[rd_ptr_reg].frame_id;
    assign payload   = res_mem[rd_ptr_reg].payload;
    assign last      = res_mem[rd_ptr_reg].last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bpcg_pkg::res_cnt_t'(bpcg_pkg::RES_DEPTH))
        else $error("result queue overflow");

    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (count_reg >= bpcg_pkg::res_cnt_t'(2)))
        else $error("first word of a pair shown without its partner queued");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

    a_move_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |=> (count_reg >= bpcg_pkg::res_cnt_t'(2)))
        else $error("pair push lost");
`endif

endmodule
`default_nettype wire
